// File: rtl/bb64_pkg.sv
package bb64_pkg;

  // Default width of the saturating character counter
  localparam int unsigned CountBitsDefault = 18;

  // Width of the encoded-length bound (4*ceil(65535/3) = 87380 fits in 18 bits)
  localparam int unsigned EncBits = 18;

  // Reset value of the decoded-byte limit
  localparam logic [15:0] MaxDecReset = 16'd32768;

  // Characters with a special role
  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'

  // APB register index
  localparam logic RegMaxDec = 1'b0;

  // Verdict codes, in priority order after OK
  typedef enum logic [2:0] {
    VerdOk      = 3'd0,
    VerdEmpty   = 3'd1,
    VerdLenMod  = 3'd2,
    VerdTooLong = 3'd3,
    VerdBadSym  = 3'd4,
    VerdDecLong = 3'd5
  } verdict_e;

  // Padding run and sticky error of one record
  typedef struct packed {
    logic [1:0] pad_run;
    logic       bad_symbol;
  } rec_flags_t;

  // One verdict beat
  typedef struct packed {
    logic        valid_res;
    verdict_e    verdict;
    logic [15:0] decoded_length;
  } result_t;

  // Base64 alphabet without padding
  function automatic logic is_data_char(input logic [7:0] c);
    logic hit;
    hit = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
          (c == PlusChar) || (c == SlashChar);
    return hit;
  endfunction

  // 4*ceil(m/3): (m+2)/3 through the reciprocal 0xAAAB / 2^17, exact below 2^17
  function automatic logic [EncBits-1:0] enc_bound(input logic [15:0] m);
    logic [16:0] n;
    logic [32:0] prod;
    n    = {1'b0, m} + 17'd2;
    prod = 33'(n) * 33'(17'h0AAAB);
    return {prod[32:17], 2'b00};
  endfunction

endpackage

// File: rtl/bb64_scan.sv
module bb64_scan
  import bb64_pkg::*;
#(
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,      // input beat accepted
  input  logic [7:0]           symbol_i,
  input  logic                 last_i,
  input  logic                 no_chars_i,
  output logic [CountBits-1:0] snap_count_o, // record state including this beat
  output rec_flags_t           snap_flags_o
);

  logic [CountBits-1:0] count_q, count_d, count_nx;
  rec_flags_t           flags_q, flags_d, flags_nx;

  // Record state after the current character
  always_comb begin
    count_nx = count_q;
    flags_nx = flags_q;
    if (!no_chars_i) begin
      if (!(&count_q)) begin
        count_nx = count_q + CountBits'(1);
      end
      if (symbol_i == PadChar) begin
        if (flags_q.pad_run == 2'd2) begin
          flags_nx.bad_symbol = 1'b1;
        end else begin
          flags_nx.pad_run = flags_q.pad_run + 2'd1;
        end
      end else if (is_data_char(symbol_i)) begin
        // data after padding is misplaced
        if (flags_q.pad_run != 2'd0) begin
          flags_nx.bad_symbol = 1'b1;
        end
        flags_nx.pad_run = 2'd0;
      end else begin
        flags_nx.bad_symbol = 1'b1;
      end
    end
  end

  // Clear after the last beat of a record
  always_comb begin
    count_d = count_q;
    flags_d = flags_q;
    if (beat_i) begin
      if (last_i) begin
        count_d = '0;
        flags_d = '0;
      end else begin
        count_d = count_nx;
        flags_d = flags_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flags_q <= '0;
    end else begin
      count_q <= count_d;
      flags_q <= flags_d;
    end
  end

  assign snap_count_o = count_nx;
  assign snap_flags_o = flags_nx;

endmodule

// File: rtl/bb64_judge.sv
module bb64_judge
  import bb64_pkg::*;
#(
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic [CountBits-1:0] count_i,
  input  rec_flags_t           flags_i,
  input  logic [15:0]          max_dec_i,
  input  logic [EncBits-1:0]   max_enc_i,
  output result_t              res_o
);

  // Working width covers both the counter and the encoded bound
  localparam int unsigned WorkBits = (CountBits > EncBits) ? CountBits : EncBits;

  logic [WorkBits-1:0] cnt_w;
  logic [WorkBits:0]   quarter;
  logic [WorkBits:0]   dec_full;

  assign cnt_w    = WorkBits'(count_i);
  assign quarter  = (WorkBits + 1)'(cnt_w[WorkBits-1:2]);
  // groups * 3 minus padding; only used once the count is within the bound
  assign dec_full = (quarter << 1) + quarter - (WorkBits + 1)'(flags_i.pad_run);

  always_comb begin
    res_o.verdict        = VerdOk;
    res_o.decoded_length = '0;
    if (cnt_w == '0) begin
      res_o.verdict = VerdEmpty;
    end else if (cnt_w[1:0] != 2'd0) begin
      res_o.verdict = VerdLenMod;
    end else if (cnt_w > WorkBits'(max_enc_i)) begin
      res_o.verdict = VerdTooLong;
    end else if (flags_i.bad_symbol) begin
      res_o.verdict = VerdBadSym;
    end else if (dec_full > (WorkBits + 1)'(max_dec_i)) begin
      res_o.verdict = VerdDecLong;
    end else begin
      res_o.decoded_length = dec_full[15:0];
    end
    res_o.valid_res = (res_o.verdict == VerdOk);
  end

endmodule

// File: rtl/bounded_base64_validator.sv
// Bounded Base64 validator: at most one character per beat, one verdict per record.
// Throughput: one input beat every cycle unless verdicts back up; the scan state updates in the accept cycle.
// Path: the verdict beat for a record passes the record snapshot register, then the verdict
//   register, and waits there while the verdict stream is stalled.
// Reset (asynchronous, active low): record state and pipeline empty,
//   the decoded-byte limit returns to 32768.
module bounded_base64_validator
  import bb64_pkg::*;
#(
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,   // last
  input  logic        s_axis_tuser,   // [0] no_chars
  // verdict stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] verdict, [18:3] decoded_length, [23:19] zero
  output logic        m_axis_tuser,   // [0] valid_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [EncBits-1:0] MaxEncReset = enc_bound(MaxDecReset);

  logic [15:0]          max_dec_q, max_dec_d;
  logic [EncBits-1:0]   max_enc_q, max_enc_d;
  logic                 cfg_wr;

  logic                 s_beat;
  logic                 out_free;
  logic                 snap_adv;

  logic [CountBits-1:0] scan_count;
  rec_flags_t           scan_flags;

  logic                 snap_vld_q, snap_vld_d;
  logic [CountBits-1:0] snap_count_q;
  rec_flags_t           snap_flags_q;

  result_t              judge_res;
  logic                 out_vld_q, out_vld_d;
  result_t              out_res_q;

  // Register file: bound and its encoded form are held together
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMaxDec);
  assign prdata = (paddr[2] == RegMaxDec) ? 32'(max_dec_q) : '0;

  always_comb begin
    max_dec_d = max_dec_q;
    max_enc_d = max_enc_q;
    if (cfg_wr) begin
      max_dec_d = pwdata[15:0];
      max_enc_d = enc_bound(pwdata[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dec_q <= MaxDecReset;
      max_enc_q <= MaxEncReset;
    end else begin
      max_dec_q <= max_dec_d;
      max_enc_q <= max_enc_d;
    end
  end

  // Handshake across the two registered stages
  assign out_free      = !out_vld_q || m_axis_tready;
  assign snap_adv      = snap_vld_q && out_free;
  assign s_axis_tready = !snap_vld_q || out_free;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  bb64_scan #(
    .CountBits(CountBits)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (s_beat),
    .symbol_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .no_chars_i  (s_axis_tuser),
    .snap_count_o(scan_count),
    .snap_flags_o(scan_flags)
  );

  // Snapshot of a finished record
  always_comb begin
    snap_vld_d = snap_vld_q;
    if (s_beat && s_axis_tlast) begin
      snap_vld_d = 1'b1;
    end else if (snap_adv) begin
      snap_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat && s_axis_tlast) begin
      snap_count_q <= scan_count;
      snap_flags_q <= scan_flags;
    end
  end

  bb64_judge #(
    .CountBits(CountBits)
  ) u_judge (
    .count_i  (snap_count_q),
    .flags_i  (snap_flags_q),
    .max_dec_i(max_dec_q),
    .max_enc_i(max_enc_q),
    .res_o    (judge_res)
  );

  // Verdict output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (snap_adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv) begin
      out_res_q <= judge_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.valid_res;
  assign m_axis_tdata  = {5'd0, out_res_q.decoded_length, out_res_q.verdict};

endmodule

// File: rtl/bb64_chk.sv
module bb64_chk
  import bb64_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled verdict beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("verdict beat changed while stalled");

  // The valid flag agrees with the verdict code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[2:0] == VerdOk)))
    else $error("valid_res disagrees with verdict");

  // A rejected record reports no decoded length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[18:3] == 16'd0))
    else $error("decoded length on a rejected record");

  // Only defined verdict codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= VerdDecLong) && (m_axis_tdata[23:19] == 5'd0))
    else $error("undefined verdict code");

  // With the output register empty, input is never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind bounded_base64_validator bb64_chk u_bb64_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
